// ===== sv/zda_pkg.sv =====
// Shared types and constants for the zone dwell alarm block.
package zda_pkg;

  localparam int TS_W     = 48;
  localparam int MINUTE_W = 11;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY = 11'd1440;
  localparam logic [15:0]         GAP_RESET       = 16'd1000;
  localparam logic [15:0]         RETRY_RESET     = 16'd1000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_CONFIGURED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTINUITY_GAP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_NO_TARGET    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_WINDOW_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ZONE_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DWELLING     = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_ALARM        = 3'd5;

  typedef struct packed {
    logic [TS_W-1:0]     frame_time;
    logic [MINUTE_W-1:0] minute_of_day;
    logic                detections_present;
    logic [COUNT_W-1:0]  hit_count;
    logic                report_accept;
  } frame_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                alarm_active;
    logic                report_request;
    logic [TS_W-1:0]     dwell_time;
  } result_t;

  typedef struct packed {
    logic            in_zone;
    logic            report_done;
    logic [TS_W-1:0] presence_start_time;
    logic [TS_W-1:0] previous_frame_time;
    logic [TS_W-1:0] last_attempt_time;
  } track_t;

  typedef struct packed {
    logic                window_enable;
    logic [MINUTE_W-1:0] window_start_minute;
    logic [MINUTE_W-1:0] window_end_minute;
    logic [31:0]         dwell_limit;
    logic                zone_configured;
    logic [15:0]         max_gap;
    logic [15:0]         retry_interval_ms;
  } cfg_t;

endpackage

// ===== sv/zda_ifs.sv =====
// Handshake channels for frames in and results out.
interface zda_frame_if;
  import zda_pkg::*;
  logic                valid;
  logic                ready;
  logic [TS_W-1:0]     frame_time;
  logic [MINUTE_W-1:0] minute_of_day;
  logic                detections_present;
  logic [COUNT_W-1:0]  hit_count;
  logic                report_accept;

  modport source (output valid, frame_time, minute_of_day, detections_present,
                  hit_count, report_accept, input ready);
  modport sink (input valid, frame_time, minute_of_day, detections_present,
                hit_count, report_accept, output ready);
endinterface

interface zda_result_if;
  import zda_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                alarm_active;
  logic                report_request;
  logic [TS_W-1:0]     dwell_time;

  modport source (output valid, status, alarm_active, report_request, dwell_time,
                  input ready);
  modport sink (input valid, status, alarm_active, report_request, dwell_time,
                output ready);
endinterface

// ===== sv/zone_dwell_alarm.sv =====
// Top level of the zone dwell alarm: config registers, tracking state, result register.
//
//  channel    dir  handshake           payload
//  frame_in   in   valid/ready         frame_time, minute_of_day, detections_present,
//                                      hit_count, report_accept
//  result_out out  valid/ready         status, alarm_active, report_request, dwell_time
//  cfg_*      in   write enable only   cfg_index selects, cfg_data carries the value
//
// A frame is captured in the input register, evaluated by combinational compare/subtract
// logic against the tracking state and then lands in the result register; a stall on
// result_out holds it there. One frame per cycle is sustained while result_out is ready.
// Reset (synchronous, rst high) empties both registers, clears tracking state and loads
// the register defaults (gap and retry at 1000 ms).
// A stalled result register holds the input register; the input register still takes a
// frame when it is empty or its frame moves on in the same cycle.
module zone_dwell_alarm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [zda_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [zda_pkg::CFG_DATA_W-1:0]       cfg_data,
  zda_frame_if.sink                            frame_in,
  zda_result_if.source                         result_out
);
  import zda_pkg::*;

  cfg_t    cfg;
  track_t  track;
  track_t  track_next;
  frame_t  held_frame;
  logic    held_valid;
  logic    take;
  result_t eval_result;
  logic    out_valid;
  result_t out_result;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_enable       <= 1'b0;
      cfg.window_start_minute <= '0;
      cfg.window_end_minute   <= '0;
      cfg.dwell_limit         <= '0;
      cfg.zone_configured     <= 1'b0;
      cfg.max_gap             <= GAP_RESET;
      cfg.retry_interval_ms   <= RETRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_ENABLE:   cfg.window_enable       <= cfg_data[0];
        REG_WINDOW_START:    cfg.window_start_minute <= cfg_data[MINUTE_W-1:0];
        REG_WINDOW_END:      cfg.window_end_minute   <= cfg_data[MINUTE_W-1:0];
        REG_DWELL_THRESHOLD: cfg.dwell_limit         <= cfg_data[31:0];
        REG_ZONE_CONFIGURED: cfg.zone_configured     <= cfg_data[0];
        REG_CONTINUITY_GAP:  cfg.max_gap             <= cfg_data[15:0];
        REG_RETRY_INTERVAL:  cfg.retry_interval_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  zda_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .take       (take),
    .held_valid (held_valid),
    .held_frame (held_frame)
  );

  zda_eval u_eval (
    .frame      (held_frame),
    .cfg        (cfg),
    .track      (track),
    .track_next (track_next),
    .result     (eval_result)
  );

  // Advance the held frame when the result register is empty or being drained
  assign take = held_valid && (!out_valid || result_out.ready);

  // Tracking state moves only with a frame, so the next frame sees this one's effect
  always_ff @(posedge clk) begin
    if (rst) begin
      track <= '0;
    end else if (take) begin
      track <= track_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= eval_result;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.status         = out_result.status;
  assign result_out.alarm_active   = out_result.alarm_active;
  assign result_out.report_request = out_result.report_request;
  assign result_out.dwell_time     = out_result.dwell_time;

endmodule

// ===== sv/zda_in_reg.sv =====
// Input holding register: captures one frame and passes it on when taken.
module zda_in_reg (
  input  logic          clk,
  input  logic          rst,
  zda_frame_if.sink     frame_in,
  input  logic          take,
  output logic          held_valid,
  output zda_pkg::frame_t held_frame
);
  import zda_pkg::*;

  logic accept;

  // Free when empty or when the held frame leaves this cycle
  assign frame_in.ready = !held_valid || take;
  assign accept         = frame_in.valid && frame_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_frame.frame_time         <= frame_in.frame_time;
      held_frame.minute_of_day      <= frame_in.minute_of_day;
      held_frame.detections_present <= frame_in.detections_present;
      held_frame.hit_count          <= frame_in.hit_count;
      held_frame.report_accept      <= frame_in.report_accept;
    end
  end

endmodule

// ===== sv/zda_eval.sv =====
// Per-frame evaluation: continuity, window, zone, dwell and report retry.
module zda_eval (
  input  zda_pkg::frame_t  frame,
  input  zda_pkg::cfg_t    cfg,
  input  zda_pkg::track_t  track,
  output zda_pkg::track_t  track_next,
  output zda_pkg::result_t result
);
  import zda_pkg::*;

  logic [TS_W-1:0] now;
  logic [TS_W:0]   prev_diff;
  logic            cont_break;
  track_t          base;
  logic            window_bad;
  logic            in_window;
  logic            no_target;
  logic [TS_W-1:0] start_time;
  logic [TS_W-1:0] elapsed;
  logic            dwell_met;
  logic [TS_W:0]   attempt_diff;
  logic            too_soon;
  logic            req;

  assign now = frame.frame_time;

  // Break on a backward step or a gap beyond the limit, once a previous frame time is set
  assign prev_diff  = {1'b0, now} - {1'b0, track.previous_frame_time};
  assign cont_break = (track.previous_frame_time != '0) &&
                      (prev_diff[TS_W] ||
                       (prev_diff[TS_W-1:0] > {{(TS_W-16){1'b0}}, cfg.max_gap}));

  always_comb begin
    base = track;
    if (cont_break) begin
      base.in_zone             = 1'b0;
      base.report_done         = 1'b0;
      base.presence_start_time = '0;
      base.last_attempt_time   = '0;
    end
  end

  assign window_bad = (cfg.window_start_minute == cfg.window_end_minute) ||
                      (cfg.window_start_minute >= MINUTES_PER_DAY) ||
                      (cfg.window_end_minute >= MINUTES_PER_DAY);

  always_comb begin
    if (cfg.window_start_minute < cfg.window_end_minute) begin
      in_window = (frame.minute_of_day >= cfg.window_start_minute) &&
                  (frame.minute_of_day < cfg.window_end_minute);
    end else begin
      in_window = (frame.minute_of_day >= cfg.window_start_minute) ||
                  (frame.minute_of_day < cfg.window_end_minute);
    end
  end

  assign no_target  = !frame.detections_present || (frame.hit_count == '0);
  assign start_time = base.in_zone ? base.presence_start_time : now;
  assign elapsed    = now - start_time;
  assign dwell_met  = elapsed >= {{(TS_W-32){1'b0}}, cfg.dwell_limit};

  // A negative difference wraps large and never counts as too soon
  assign attempt_diff = {1'b0, now} - {1'b0, base.last_attempt_time};
  assign too_soon     = (base.last_attempt_time != '0) && !attempt_diff[TS_W] &&
                        (attempt_diff[TS_W-1:0] <
                         {{(TS_W-16){1'b0}}, cfg.retry_interval_ms});
  assign req          = !base.report_done && !too_soon;

  always_comb begin
    track_next                     = '0;
    track_next.previous_frame_time = now;
    result                         = '0;
    priority if (cfg.window_enable && window_bad) begin
      result.status = STATUS_WINDOW_BAD;
    end else if (cfg.window_enable && !in_window) begin
      result.status = STATUS_OUTSIDE;
    end else if (!cfg.zone_configured) begin
      result.status = STATUS_ZONE_INVALID;
    end else if (no_target) begin
      result.status = STATUS_NO_TARGET;
    end else if (!dwell_met) begin
      result.status                  = STATUS_DWELLING;
      result.dwell_time              = elapsed;
      track_next.in_zone             = 1'b1;
      track_next.presence_start_time = start_time;
      track_next.report_done         = base.report_done;
      track_next.last_attempt_time   = base.last_attempt_time;
    end else begin
      result.status                  = STATUS_ALARM;
      result.alarm_active            = 1'b1;
      result.report_request          = req;
      result.dwell_time              = elapsed;
      track_next.in_zone             = 1'b1;
      track_next.presence_start_time = start_time;
      track_next.report_done         = base.report_done || (req && frame.report_accept);
      track_next.last_attempt_time   = req ? now : base.last_attempt_time;
    end
  end

endmodule

// ===== sim/tb_zone_dwell_alarm.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the zone dwell alarm: directed frames, then random phases.
module tb_zone_dwell_alarm;
  import zda_pkg::*;

  // Index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // Cycles the result side refuses transactions during the back-pressure test
  localparam int LONG_HOLD = 300;
  // Cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 125;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zda_frame_if  frame_if ();
  zda_result_if result_if ();

  zone_dwell_alarm DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_in   (frame_if),
    .result_out (result_if)
  );

  always #5 clk = ~clk;

  // Shadow copies of the register file and of the presence tracker
  cfg_t   zone_cfg;
  track_t presence;

  frame_t  frames_to_send[$];   // frames waiting for the driver
  result_t outcome_q[$];        // predicted results, oldest first
  frame_t  offered;             // frame currently on the input channel

  int          mismatches = 0;
  int          burst_left;
  int          gap_left;
  int          hold_requests = 0;
  int          holds_served;
  int          hold_left;
  int          pattern_age;
  logic [7:0]  stall_pattern;
  int          quiet_cycles;
  logic [TS_W-1:0] stamp_clock;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Forget the current presence; the previous frame time survives on purpose.
  function automatic void drop_presence();
    presence.in_zone             = 1'b0;
    presence.report_done         = 1'b0;
    presence.presence_start_time = '0;
    presence.last_attempt_time   = '0;
  endfunction

  // Work out the result of one frame and advance the shadow tracker.
  function automatic result_t dwell_outcome(input frame_t f);
    result_t             r;
    logic [TS_W-1:0]     now;
    logic [MINUTE_W-1:0] ws;
    logic [MINUTE_W-1:0] we;
    logic [MINUTE_W-1:0] m;
    logic                in_win;
    r   = '0;
    now = f.frame_time;
    ws  = zone_cfg.window_start_minute;
    we  = zone_cfg.window_end_minute;
    m   = f.minute_of_day;

    // A zero previous time means no frame seen yet: skip the continuity check
    if (presence.previous_frame_time != '0 &&
        (now < presence.previous_frame_time ||
         now - presence.previous_frame_time > TS_W'(zone_cfg.max_gap)))
      drop_presence();
    presence.previous_frame_time = now;

    if (zone_cfg.window_enable) begin
      if (ws == we || ws >= MINUTES_PER_DAY || we >= MINUTES_PER_DAY) begin
        drop_presence();
        r.status = STATUS_WINDOW_BAD;
        return r;
      end
      // Start above end wraps past midnight; out-of-range minutes compare as they are
      in_win = (ws < we) ? (m >= ws && m < we) : (m >= ws || m < we);
      if (!in_win) begin
        drop_presence();
        r.status = STATUS_OUTSIDE;
        return r;
      end
    end

    if (!zone_cfg.zone_configured) begin
      drop_presence();
      r.status = STATUS_ZONE_INVALID;
      return r;
    end
    if (!f.detections_present || f.hit_count == '0) begin
      drop_presence();
      r.status = STATUS_NO_TARGET;
      return r;
    end

    if (!presence.in_zone) begin
      presence.in_zone             = 1'b1;
      presence.presence_start_time = now;
    end
    r.dwell_time = now - presence.presence_start_time;
    if (r.dwell_time < TS_W'(zone_cfg.dwell_limit)) begin
      r.status = STATUS_DWELLING;
      return r;
    end

    r.status       = STATUS_ALARM;
    r.alarm_active = 1'b1;
    // A zero attempt time means never tried, so an attempt at time zero may repeat at once
    if (!presence.report_done &&
        !(presence.last_attempt_time != '0 &&
          now - presence.last_attempt_time < TS_W'(zone_cfg.retry_interval_ms))) begin
      presence.last_attempt_time = now;
      r.report_request           = 1'b1;
      if (f.report_accept)
        presence.report_done = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued frames in bursts, predict each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      frame_if.valid <= 1'b0;
      presence       = '0;
      burst_left     = 0;
      gap_left       = 0;
    end else begin
      if (frame_if.valid && frame_if.ready)
        outcome_q.push_back(dwell_outcome(offered));

      // The slot is free when nothing is offered or the offer was just taken
      if (!frame_if.valid || frame_if.ready) begin
        if (gap_left > 0 || frames_to_send.size() == 0) begin
          frame_if.valid <= 1'b0;
          if (gap_left > 0)
            gap_left--;
        end else begin
          offered = frames_to_send.pop_front();
          frame_if.valid              <= 1'b1;
          frame_if.frame_time         <= offered.frame_time;
          frame_if.minute_of_day      <= offered.minute_of_day;
          frame_if.detections_present <= offered.detections_present;
          frame_if.hit_count          <= offered.hit_count;
          frame_if.report_accept      <= offered.report_accept;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // End of burst: pick the next burst and the pause before it; no pause a quarter of the time
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transaction, stall on a rotating pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_pattern   = 8'hFF;
      pattern_age     = 0;
      hold_left       = 0;
      holds_served    = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with no frame outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (result_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_if.status);
            mismatches++;
          end
          if (result_if.alarm_active !== want.alarm_active) begin
            $error("alarm_active: expected %0b, got %0b", want.alarm_active,
                   result_if.alarm_active);
            mismatches++;
          end
          if (result_if.report_request !== want.report_request) begin
            $error("report_request: expected %0b, got %0b", want.report_request,
                   result_if.report_request);
            mismatches++;
          end
          if (result_if.dwell_time !== want.dwell_time) begin
            $error("dwell_time: expected %0d, got %0d", want.dwell_time,
                   result_if.dwell_time);
            mismatches++;
          end
        end
      end

      // Start a long hold-off when the stimulus asks for one
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end

      // Swap the stall pattern now and then; a third of the time never stall.
      // Bit 0 forced high so a pattern always lets something through.
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom_range(0, 255)) | 8'h01);
        pattern_age   = $urandom_range(16, 128);
      end else begin
        pattern_age--;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};

      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= stall_pattern[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up when no transaction moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_zone_dwell_alarm failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the shadow copy; only called while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_ENABLE:   zone_cfg.window_enable       = val[0];
      REG_WINDOW_START:    zone_cfg.window_start_minute = val[MINUTE_W-1:0];
      REG_WINDOW_END:      zone_cfg.window_end_minute   = val[MINUTE_W-1:0];
      REG_DWELL_THRESHOLD: zone_cfg.dwell_limit         = val;
      REG_ZONE_CONFIGURED: zone_cfg.zone_configured     = val[0];
      REG_CONTINUITY_GAP:  zone_cfg.max_gap             = val[15:0];
      REG_RETRY_INTERVAL:  zone_cfg.retry_interval_ms   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_frame(input logic [TS_W-1:0] ts, input logic [MINUTE_W-1:0] minute,
                             input logic dets, input logic [COUNT_W-1:0] count,
                             input logic accept);
    frame_t f;
    f.frame_time         = ts;
    f.minute_of_day      = minute;
    f.detections_present = dets;
    f.hit_count          = count;
    f.report_accept      = accept;
    frames_to_send.push_back(f);
  endtask

  // Hold the sender idle until every queued frame has been sent and answered.
  task automatic wait_for_results();
    while (frames_to_send.size() != 0 || frame_if.valid || outcome_q.size() != 0)
      @(negedge clk);
  endtask

  // Mostly a minute inside a valid window, so presence can build up.
  function automatic logic [MINUTE_W-1:0] pick_minute();
    int unsigned ws;
    int unsigned we;
    int unsigned span;
    ws = 32'(zone_cfg.window_start_minute);
    we = 32'(zone_cfg.window_end_minute);
    if (!zone_cfg.window_enable || ws == we || ws >= MINUTES_PER_DAY || we >= MINUTES_PER_DAY ||
        $urandom_range(0, 9) == 0)
      return MINUTE_W'($urandom_range(0, MINUTES_PER_DAY - 1));
    span = (ws < we) ? we - ws : MINUTES_PER_DAY - ws + we;
    return MINUTE_W'((ws + $urandom_range(0, span - 1)) % MINUTES_PER_DAY);
  endfunction

  // Pick a register setting for one phase, extremes now and then.
  task automatic apply_random_settings();
    logic [CFG_DATA_W-1:0] ws;
    logic [CFG_DATA_W-1:0] we;
    logic [CFG_DATA_W-1:0] dwell;
    logic [CFG_DATA_W-1:0] gap;
    logic [CFG_DATA_W-1:0] retry;
    int                    pick;
    ws = $urandom_range(0, MINUTES_PER_DAY - 1);
    we = $urandom_range(0, MINUTES_PER_DAY - 1);
    if ($urandom_range(0, 7) == 0) we = ws;
    if ($urandom_range(0, 15) == 0) ws = $urandom_range(MINUTES_PER_DAY, 2047);
    pick = $urandom_range(0, 7);
    if (pick == 0)      dwell = 0;
    else if (pick == 1) dwell = 32'hFFFF_FFFF;
    else if (pick == 2) dwell = $urandom_range(3000, 20000);
    else                dwell = $urandom_range(1, 3000);
    pick = $urandom_range(0, 7);
    gap  = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(100, 3000);
    pick  = $urandom_range(0, 7);
    retry = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(1, 2000);
    write_reg(REG_WINDOW_ENABLE, $urandom_range(0, 1));
    write_reg(REG_WINDOW_START, ws);
    write_reg(REG_WINDOW_END, we);
    write_reg(REG_DWELL_THRESHOLD, dwell);
    write_reg(REG_ZONE_CONFIGURED, CFG_DATA_W'($urandom_range(0, 9) != 0));
    write_reg(REG_CONTINUITY_GAP, gap);
    write_reg(REG_RETRY_INTERVAL, retry);
  endtask

  // Queue frames: mostly continuous presence in the window, the rest breaks it.
  task automatic queue_random_frames(input int count);
    frame_t f;
    int     kind;
    for (int i = 0; i < count; i++) begin
      kind                 = $urandom_range(0, 99);
      f.minute_of_day      = pick_minute();
      f.detections_present = 1'b1;
      f.hit_count          = COUNT_W'($urandom_range(1, 255));
      f.report_accept      = ($urandom_range(0, 3) == 0);
      if (kind < 80) begin
        // Step within the allowed gap: presence carries on
        stamp_clock += TS_W'($urandom_range(0, zone_cfg.max_gap));
      end else if (kind < 87) begin
        // Step past the gap: presence restarts
        stamp_clock += TS_W'(zone_cfg.max_gap + $urandom_range(1, 5000));
      end else if (kind < 91) begin
        // Step backward in time
        stamp_clock -= TS_W'($urandom_range(1, 2000));
      end else if (kind < 95) begin
        // Lose the detections or the targets
        f.detections_present = 1'($urandom_range(0, 1));
        if (f.detections_present)
          f.hit_count = '0;
        stamp_clock += TS_W'($urandom_range(0, zone_cfg.max_gap));
      end else begin
        // Noise: any minute, any count, sometimes an unset timestamp
        f.minute_of_day      = MINUTE_W'($urandom_range(0, 2047));
        f.detections_present = 1'($urandom_range(0, 1));
        f.hit_count          = COUNT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
          stamp_clock = '0;
        else
          stamp_clock += TS_W'($urandom_range(0, 3000));
      end
      f.frame_time = stamp_clock;
      frames_to_send.push_back(f);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge
    rst                         = 1'b1;
    cfg_we                      = 1'b0;
    cfg_index                   = '0;
    cfg_data                    = '0;
    frame_if.valid              = 1'b0;
    frame_if.frame_time         = '0;
    frame_if.minute_of_day      = '0;
    frame_if.detections_present = 1'b0;
    frame_if.hit_count          = '0;
    frame_if.report_accept      = 1'b0;
    result_if.ready             = 1'b0;

    // Register defaults after reset
    zone_cfg                   = '0;
    zone_cfg.max_gap           = GAP_RESET;
    zone_cfg.retry_interval_ms = RETRY_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part ---

    // Zone not configured yet: invalid zone
    queue_frame(48'd0, 11'd0, 1'b1, 8'd1, 1'b0);
    wait_for_results();

    write_reg(REG_ZONE_CONFIGURED, 1);
    write_reg(REG_DWELL_THRESHOLD, 0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    // Alarm at timestamp zero: the attempt leaves no attempt time, so retry at once
    queue_frame(48'd0, 11'd0, 1'b1, 8'd255, 1'b0);
    queue_frame(48'd0, 11'd0, 1'b1, 8'd1, 1'b1);
    // Report taken: accept without an attempt is ignored
    queue_frame(48'd5, 11'd0, 1'b1, 8'd1, 1'b1);
    // Missing detection results, then no target counted
    queue_frame(48'd10, 11'd0, 1'b0, 8'd5, 1'b0);
    queue_frame(48'd20, 11'd0, 1'b1, 8'd0, 1'b0);
    // Retry interval: too early, then exactly on time
    queue_frame(48'd30, 11'd0, 1'b1, 8'd1, 1'b0);
    queue_frame(48'd500, 11'd0, 1'b1, 8'd1, 1'b0);
    queue_frame(48'd1030, 11'd0, 1'b1, 8'd1, 1'b1);
    // Gap one past the limit, then a backward step
    queue_frame(48'd2031, 11'd0, 1'b1, 8'd1, 1'b0);
    queue_frame(48'd2000, 11'd0, 1'b1, 8'd1, 1'b0);
    wait_for_results();

    // Window wrapping past midnight
    write_reg(REG_WINDOW_ENABLE, 1);
    write_reg(REG_WINDOW_START, 1380);
    write_reg(REG_WINDOW_END, 60);
    write_reg(REG_DWELL_THRESHOLD, 100);
    queue_frame(48'd3000, 11'd1439, 1'b1, 8'd3, 1'b0);
    queue_frame(48'd3050, 11'd30, 1'b1, 8'd3, 1'b0);
    queue_frame(48'd3100, 11'd60, 1'b1, 8'd3, 1'b0);
    queue_frame(48'd3150, 11'd2047, 1'b1, 8'd3, 1'b0);
    queue_frame(48'd3200, 11'd1379, 1'b1, 8'd3, 1'b0);
    wait_for_results();

    // Misconfigured window: start equal to end, then start out of range
    write_reg(REG_WINDOW_END, 1380);
    queue_frame(48'd3250, 11'd1400, 1'b1, 8'd3, 1'b0);
    wait_for_results();
    write_reg(REG_WINDOW_START, 2047);
    write_reg(REG_WINDOW_END, 10);
    queue_frame(48'd3300, 11'd5, 1'b1, 8'd3, 1'b0);
    wait_for_results();

    // Largest timestamps with the widest gap and longest dwell
    write_reg(REG_WINDOW_ENABLE, 0);
    write_reg(REG_CONTINUITY_GAP, 32'h0000_FFFF);
    write_reg(REG_DWELL_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_RETRY_INTERVAL, 0);
    queue_frame(48'hFFFF_FFFF_FFFF, 11'd1439, 1'b1, 8'd255, 1'b1);
    queue_frame(48'hFFFF_FFFF_FFFE, 11'd1439, 1'b1, 8'd255, 1'b1);
    wait_for_results();

    // Zero gap: only an unchanged timestamp keeps presence
    write_reg(REG_DWELL_THRESHOLD, 0);
    write_reg(REG_RETRY_INTERVAL, 32'h0000_FFFF);
    write_reg(REG_CONTINUITY_GAP, 0);
    queue_frame(48'd100, 11'd0, 1'b1, 8'd1, 1'b0);
    queue_frame(48'd100, 11'd0, 1'b1, 8'd1, 1'b0);
    queue_frame(48'd101, 11'd0, 1'b1, 8'd1, 1'b0);
    wait_for_results();

    // --- Random phases; each drains fully before the registers change ---
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_random_settings();
      if ($urandom_range(0, 1))
        stamp_clock = {16'($urandom_range(0, 65535)), 32'($urandom())};
      else
        stamp_clock = TS_W'($urandom_range(1, 100000));
      queue_random_frames(FRAMES_PER_PHASE);
      if (phase == 2) begin
        // Block the result side while frames keep coming, so the block backs up
        repeat (4) @(negedge clk);
        hold_requests++;
      end
      wait_for_results();
    end

    // Let any stray result show up before judging
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0)
      $display("tb_zone_dwell_alarm passed");
    else
      $display("tb_zone_dwell_alarm failed");
    $finish;
  end

endmodule
